// ===== hdl/pcod_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the point cloud obstacle detector.
// Used by every module under hdl; depends on nothing.
package pcod_pkg;

	// Default frame size limit for the side counters
	localparam int unsigned DEF_MAX_FRAME_POINTS = 65536;

	// Configuration port geometry
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 17;

	// Register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_ROI_MIN_FORWARD = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_ROI_MAX_FORWARD = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_ROI_HALF_WIDTH  = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_ROI_MIN_HEIGHT  = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_ROI_MAX_HEIGHT  = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_MIN_POINTS      = 3'd5;
	localparam logic [CFG_INDEX_W-1:0] REG_SIDE_DEADBAND   = 3'd6;
	localparam logic [CFG_INDEX_W-1:0] REG_MAX_TURN_RATE   = 3'd7;

	// Register reset values
	localparam logic [14:0]        RST_ROI_MIN_FORWARD = 15'd200;
	localparam logic [14:0]        RST_ROI_MAX_FORWARD = 15'd2000;
	localparam logic [14:0]        RST_ROI_HALF_WIDTH  = 15'd800;
	localparam logic signed [15:0] RST_ROI_MIN_HEIGHT  = 16'sd80;
	localparam logic signed [15:0] RST_ROI_MAX_HEIGHT  = 16'sd1000;
	localparam logic [16:0]        RST_MIN_POINTS      = 17'd8;
	localparam logic [16:0]        RST_SIDE_DEADBAND   = 17'd3;
	localparam logic [15:0]        RST_MAX_TURN_RATE   = 16'd800;

	// Square root unit: one result bit per step, two operand bits per step over a 32-bit operand
	localparam int ROOT_STEPS  = 16;
	localparam int ROOT_CNT_W  = 4;

	typedef struct packed {
		logic [14:0]        roi_min_forward;
		logic [14:0]        roi_max_forward;
		logic [14:0]        roi_half_width;
		logic signed [15:0] roi_min_height;
		logic signed [15:0] roi_max_height;
		logic [16:0]        min_points;
		logic [16:0]        side_deadband;
		logic [15:0]        max_turn_rate;
	} pcod_cfg_t;

	// Controller commands to the datapath
	typedef struct packed {
		logic take;    // point transfer this cycle
		logic finish;  // close the frame, start the root
		logic step;    // one square root iteration
		logic load;    // write the result register
	} pcod_cmd_t;

	// Datapath status to the controller
	typedef struct packed {
		logic root_last;  // current step is the final root iteration
		logic out_busy;   // result register holds an untaken result
	} pcod_sts_t;

	typedef enum logic [2:0] {
		ST_RUN,
		ST_DRAIN,
		ST_FINAL,
		ST_ROOT,
		ST_EMIT
	} pcod_state_t;

endpackage

// ===== hdl/pcod_isqrt.sv =====
`timescale 1ns / 1ps
// Iterative integer square root, floor of sqrt of a 32-bit operand.
// Two operand bits per step; depends on pcod_pkg.
module pcod_isqrt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        step,
	input  logic [31:0] operand,
	output logic [15:0] root,
	output logic        last
);

	logic [31:0]                     op_q;
	logic [17:0]                     rem_q;
	logic [15:0]                     root_q;
	logic [pcod_pkg::ROOT_CNT_W-1:0] cnt_q;
	logic [19:0]                     rem_shift;
	logic [19:0]                     trial;
	logic [19:0]                     rem_diff;
	logic                            fits;

	// Trial subtract of the next digit
	always_comb begin
		rem_shift = {rem_q, op_q[31:30]};
		trial     = {2'b00, root_q, 2'b01};
		rem_diff  = rem_shift - trial;
		fits      = rem_shift >= trial;
	end

	// Step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= '0;
		end else if (step) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	// Operand, remainder and partial root
	always_ff @(posedge clk) begin
		if (start) begin
			op_q   <= operand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (step) begin
			op_q <= {op_q[29:0], 2'b00};
			if (fits) begin
				rem_q  <= rem_diff[17:0];
				root_q <= {root_q[14:0], 1'b1};
			end else begin
				rem_q  <= rem_shift[17:0];
				root_q <= {root_q[14:0], 1'b0};
			end
		end
	end

	assign root = root_q;
	assign last = cnt_q == pcod_pkg::ROOT_CNT_W'(pcod_pkg::ROOT_STEPS - 1);

endmodule

// ===== hdl/pcod_datapath.sv =====
`timescale 1ns / 1ps
// Datapath: box test, squared distance, frame accumulators, decision and
// result register. Depends on pcod_pkg and pcod_isqrt.
module pcod_datapath #(
	parameter int unsigned MAX_FRAME_POINTS = pcod_pkg::DEF_MAX_FRAME_POINTS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  pcod_pkg::pcod_cmd_t cmd,
	output pcod_pkg::pcod_sts_t sts,
	input  pcod_pkg::pcod_cfg_t cfg,
	input  logic signed [15:0]  point_x,
	input  logic signed [15:0]  point_y,
	input  logic signed [15:0]  point_z,
	input  logic                point_valid,
	output logic                out_valid,
	input  logic                out_stall,
	output logic                obstacle_found,
	output logic [15:0]         closest_range,
	output logic signed [16:0]  turn_command,
	output logic [16:0]         box_point_count
);

	localparam int CNT_W = $clog2(MAX_FRAME_POINTS + 1);
	localparam int SUM_W = CNT_W + 1;
	localparam int CMP_W = ((SUM_W > 17) ? SUM_W : 17) + 1;

	// Stage 1 signals
	logic signed [16:0] x17;
	logic signed [16:0] y17;
	logic [16:0]        ax;
	logic [16:0]        ay;
	logic [33:0]        px;
	logic [33:0]        py;
	logic               in_box;
	logic               box_s1;
	logic               left_s1;
	logic [30:0]        sqx_s1;
	logic [30:0]        sqy_s1;

	// Frame state
	logic [31:0]      min_q;
	logic [CNT_W-1:0] left_q;
	logic [CNT_W-1:0] right_q;
	logic             dir_left_q;
	logic [31:0]      d2;

	// Decision
	logic [SUM_W-1:0]        sum;
	logic [CMP_W-1:0]        count;
	logic [CMP_W-1:0]        need;
	logic signed [CMP_W-1:0] diff;
	logic [CMP_W-1:0]        adiff;
	logic                    enough;
	logic                    found_q;
	logic [16:0]             count_q;

	logic [15:0] root;
	logic        root_last;

	// Box test and squares
	always_comb begin
		x17 = {point_x[15], point_x};
		y17 = {point_y[15], point_y};
		ax  = point_x[15] ? 17'(-x17) : 17'(x17);
		ay  = point_y[15] ? 17'(-y17) : 17'(y17);
		px  = {17'd0, ax} * {17'd0, ax};
		py  = {17'd0, ay} * {17'd0, ay};
		in_box = (x17 >= $signed({2'b00, cfg.roi_min_forward})) &&
			(x17 <= $signed({2'b00, cfg.roi_max_forward})) &&
			(ay <= {2'b00, cfg.roi_half_width}) &&
			(point_z >= cfg.roi_min_height) &&
			(point_z <= cfg.roi_max_height);
	end

	// Stage 1 register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_s1 <= 1'b0;
		end else begin
			box_s1 <= cmd.take && point_valid && in_box;
		end
	end

	always_ff @(posedge clk) begin
		left_s1 <= !point_y[15];
		sqx_s1  <= px[30:0];
		sqy_s1  <= py[30:0];
	end

	assign d2 = {1'b0, sqx_s1} + {1'b0, sqy_s1};

	// Frame decision from the closed counters
	always_comb begin
		sum   = SUM_W'(left_q) + SUM_W'(right_q);
		count = (sum > SUM_W'(MAX_FRAME_POINTS)) ? CMP_W'(MAX_FRAME_POINTS) : CMP_W'(sum);
		need  = (cfg.min_points == '0) ? CMP_W'(1) : CMP_W'(cfg.min_points);
		enough = count >= need;
		diff  = $signed(CMP_W'(left_q)) - $signed(CMP_W'(right_q));
		adiff = diff[CMP_W-1] ? CMP_W'(-diff) : CMP_W'(diff);
	end

	// Accumulate box points; clear on frame close
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q      <= '1;
			left_q     <= '0;
			right_q    <= '0;
			dir_left_q <= 1'b1;
		end else if (cmd.finish) begin
			min_q   <= '1;
			left_q  <= '0;
			right_q <= '0;
			if (!enough) begin
				dir_left_q <= 1'b1;
			end else if (adiff > CMP_W'(cfg.side_deadband)) begin
				dir_left_q <= diff[CMP_W-1];
			end
		end else if (box_s1) begin
			if (d2 < min_q) begin
				min_q <= d2;
			end
			if (left_s1) begin
				if (left_q < CNT_W'(MAX_FRAME_POINTS)) begin
					left_q <= left_q + 1'b1;
				end
			end else begin
				if (right_q < CNT_W'(MAX_FRAME_POINTS)) begin
					right_q <= right_q + 1'b1;
				end
			end
		end
	end

	// Hold the frame verdict while the root runs
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			found_q <= enough;
			count_q <= count[16:0];
		end
	end

	pcod_isqrt u_isqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.finish),
		.step    (cmd.step),
		.operand (min_q),
		.root    (root),
		.last    (root_last)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.load) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			obstacle_found  <= found_q;
			closest_range   <= found_q ? root : '0;
			box_point_count <= count_q;
			if (!found_q) begin
				turn_command <= '0;
			end else if (dir_left_q) begin
				turn_command <= $signed({1'b0, cfg.max_turn_rate});
			end else begin
				turn_command <= -$signed({1'b0, cfg.max_turn_rate});
			end
		end
	end

	assign sts.root_last = root_last;
	assign sts.out_busy  = out_valid && out_stall;

endmodule

// ===== hdl/pcod_ctrl.sv =====
`timescale 1ns / 1ps
// Controller state machine: point transfers, frame close, root steps, result load.
// Depends on pcod_pkg.
module pcod_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                last_point,
	input  pcod_pkg::pcod_sts_t sts,
	output pcod_pkg::pcod_cmd_t cmd
);

	pcod_pkg::pcod_state_t state_q;
	pcod_pkg::pcod_state_t state_n;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pcod_pkg::ST_RUN;
		end else begin
			state_q <= state_n;
		end
	end

	// Next state and commands
	always_comb begin
		state_n  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			pcod_pkg::ST_RUN: begin
				in_stall = 1'b0;
				cmd.take = in_valid;
				if (in_valid && last_point) begin
					state_n = pcod_pkg::ST_DRAIN;
				end
			end
			pcod_pkg::ST_DRAIN: begin
				state_n = pcod_pkg::ST_FINAL;
			end
			pcod_pkg::ST_FINAL: begin
				cmd.finish = 1'b1;
				state_n    = pcod_pkg::ST_ROOT;
			end
			pcod_pkg::ST_ROOT: begin
				cmd.step = 1'b1;
				if (sts.root_last) begin
					state_n = pcod_pkg::ST_EMIT;
				end
			end
			pcod_pkg::ST_EMIT: begin
				if (!sts.out_busy) begin
					cmd.load = 1'b1;
					state_n  = pcod_pkg::ST_RUN;
				end
			end
			default: begin
				state_n = pcod_pkg::ST_RUN;
			end
		endcase
	end

endmodule

// ===== hdl/point_cloud_obstacle_detector.sv =====
`timescale 1ns / 1ps
// Point cloud obstacle detector top level: configuration registers, controller, datapath.
// Throughput: one point per cycle within a frame; after the last point, input stalls.
// After the last point transfer the result passes a drain state, the frame close, 16 square root
// steps and the load; it waits longer while an earlier result is still stalled.
// Reset (arst_n low, asynchronous): registers to defaults, frame cleared, direction left.
module point_cloud_obstacle_detector #(
	parameter int unsigned MAX_FRAME_POINTS = pcod_pkg::DEF_MAX_FRAME_POINTS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [pcod_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [pcod_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [15:0]                  point_x,
	input  logic signed [15:0]                  point_y,
	input  logic signed [15:0]                  point_z,
	input  logic                                point_valid,
	input  logic                                last_point,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                obstacle_found,
	output logic [15:0]                         closest_range,
	output logic signed [16:0]                  turn_command,
	output logic [16:0]                         box_point_count
);

	pcod_pkg::pcod_cfg_t cfg_q;
	pcod_pkg::pcod_cmd_t cmd;
	pcod_pkg::pcod_sts_t sts;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.roi_min_forward <= pcod_pkg::RST_ROI_MIN_FORWARD;
			cfg_q.roi_max_forward <= pcod_pkg::RST_ROI_MAX_FORWARD;
			cfg_q.roi_half_width  <= pcod_pkg::RST_ROI_HALF_WIDTH;
			cfg_q.roi_min_height  <= pcod_pkg::RST_ROI_MIN_HEIGHT;
			cfg_q.roi_max_height  <= pcod_pkg::RST_ROI_MAX_HEIGHT;
			cfg_q.min_points      <= pcod_pkg::RST_MIN_POINTS;
			cfg_q.side_deadband   <= pcod_pkg::RST_SIDE_DEADBAND;
			cfg_q.max_turn_rate   <= pcod_pkg::RST_MAX_TURN_RATE;
		end else if (cfg_we) begin
			unique case (cfg_index)
				pcod_pkg::REG_ROI_MIN_FORWARD: cfg_q.roi_min_forward <= cfg_wdata[14:0];
				pcod_pkg::REG_ROI_MAX_FORWARD: cfg_q.roi_max_forward <= cfg_wdata[14:0];
				pcod_pkg::REG_ROI_HALF_WIDTH:  cfg_q.roi_half_width  <= cfg_wdata[14:0];
				pcod_pkg::REG_ROI_MIN_HEIGHT:  cfg_q.roi_min_height  <= $signed(cfg_wdata[15:0]);
				pcod_pkg::REG_ROI_MAX_HEIGHT:  cfg_q.roi_max_height  <= $signed(cfg_wdata[15:0]);
				pcod_pkg::REG_MIN_POINTS:      cfg_q.min_points      <= cfg_wdata;
				pcod_pkg::REG_SIDE_DEADBAND:   cfg_q.side_deadband   <= cfg_wdata;
				pcod_pkg::REG_MAX_TURN_RATE:   cfg_q.max_turn_rate   <= cfg_wdata[15:0];
				default: begin
				end
			endcase
		end
	end

	pcod_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.last_point (last_point),
		.sts        (sts),
		.cmd        (cmd)
	);

	pcod_datapath #(
		.MAX_FRAME_POINTS (MAX_FRAME_POINTS)
	) u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.cfg             (cfg_q),
		.point_x         (point_x),
		.point_y         (point_y),
		.point_z         (point_z),
		.point_valid     (point_valid),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.obstacle_found  (obstacle_found),
		.closest_range   (closest_range),
		.turn_command    (turn_command),
		.box_point_count (box_point_count)
	);

endmodule

// ===== tb/sv/point_cloud_obstacle_detector_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for point_cloud_obstacle_detector: random and directed point frames,
// predicted frame results, field-by-field checks. Depends on pcod_pkg and the top level only.
module point_cloud_obstacle_detector_tb;

	localparam int          FRAME_CAP   = int'(pcod_pkg::DEF_MAX_FRAME_POINTS);
	localparam int          TAIL_CYCLES = 40;
	localparam int          HOLD_CYCLES = 400;
	localparam int unsigned LIMIT       = 1_000_000;

	typedef struct {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic signed [15:0] z;
		logic               pv;
		logic               last;
	} point_t;

	typedef struct {
		logic               found;
		logic [15:0]        near_mm;
		logic signed [16:0] turn;
		logic [16:0]        count;
	} frame_result_t;

	// DUT connections, all inputs known from time zero
	logic                             clk         = 1'b0;
	logic                             arst_n      = 1'b0;
	logic                             cfg_we      = 1'b0;
	logic [pcod_pkg::CFG_INDEX_W-1:0] cfg_index   = '0;
	logic [pcod_pkg::CFG_DATA_W-1:0]  cfg_wdata   = '0;
	logic                             in_valid    = 1'b0;
	logic                             in_stall;
	logic signed [15:0]               point_x     = '0;
	logic signed [15:0]               point_y     = '0;
	logic signed [15:0]               point_z     = '0;
	logic                             point_valid = 1'b0;
	logic                             last_point  = 1'b0;
	logic                             out_valid;
	logic                             out_stall   = 1'b0;
	logic                             obstacle_found;
	logic [15:0]                      closest_range;
	logic signed [16:0]               turn_command;
	logic [16:0]                      box_point_count;

	// Predictor copy of the registers and the per-frame state
	pcod_pkg::pcod_cfg_t roi;
	logic [31:0]         near_d2;
	logic [16:0]         left_n;
	logic [16:0]         right_n;
	logic                turn_left;

	point_t        point_q[$];
	frame_result_t frame_q[$];
	point_t        offer;
	frame_result_t want;

	bit          in_taken;
	bit          no_gaps;
	bit          hold_req;
	bit          hold_done;
	int          hold_cnt;
	int unsigned cycles;
	int          mismatches;
	int          points_sent;
	int          frames_checked;
	int          settings_run;

	point_cloud_obstacle_detector u_top (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_wdata       (cfg_wdata),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.point_x         (point_x),
		.point_y         (point_y),
		.point_z         (point_z),
		.point_valid     (point_valid),
		.last_point      (last_point),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.obstacle_found  (obstacle_found),
		.closest_range   (closest_range),
		.turn_command    (turn_command),
		.box_point_count (box_point_count)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// ---------------------------------------------------------------- predictor

	function automatic void clear_frame_state();
		near_d2 = '1;
		left_n  = '0;
		right_n = '0;
	endfunction

	// Fold one transferred point into the frame state
	function automatic void accumulate_point(point_t p);
		int     xi, yi, zi, ay;
		longint d2;
		xi = int'(p.x);
		yi = int'(p.y);
		zi = int'(p.z);
		ay = (yi < 0) ? -yi : yi;
		if (p.pv && xi >= int'(roi.roi_min_forward) && xi <= int'(roi.roi_max_forward) &&
				ay <= int'(roi.roi_half_width) &&
				zi >= int'(roi.roi_min_height) &&
				zi <= int'(roi.roi_max_height)) begin
			d2 = longint'(xi) * longint'(xi) + longint'(ay) * longint'(ay);
			if (d2 < longint'(near_d2))
				near_d2 = d2[31:0];
			if (yi >= 0) begin
				if (int'(left_n) < FRAME_CAP) left_n = left_n + 17'd1;
			end else begin
				if (int'(right_n) < FRAME_CAP) right_n = right_n + 17'd1;
			end
		end
	endfunction

	// Floor square root, one result bit per trial from the top
	function automatic logic [15:0] floor_root(logic [31:0] v);
		longint r, t;
		r = 0;
		for (int b = 15; b >= 0; b--) begin
			t = r | (longint'(1) << b);
			if (t * t <= longint'(v))
				r = t;
		end
		return r[15:0];
	endfunction

	// Close the frame: form its result, update the held direction, clear
	function automatic frame_result_t close_frame();
		frame_result_t r;
		longint        cnt, need, d, ad;
		cnt  = longint'(left_n) + longint'(right_n);
		need = (roi.min_points == '0) ? longint'(1) : longint'(roi.min_points);
		if (cnt > longint'(FRAME_CAP))
			cnt = longint'(FRAME_CAP);
		r.found   = 1'b0;
		r.near_mm = '0;
		r.turn    = '0;
		if (cnt == 0 || cnt < need) begin
			turn_left = 1'b1;
		end else begin
			d  = longint'(left_n) - longint'(right_n);
			ad = (d < 0) ? -d : d;
			if (ad > longint'(roi.side_deadband))
				turn_left = (d < 0);
			r.found   = 1'b1;
			r.near_mm = floor_root(near_d2);
			r.turn    = turn_left ? $signed({1'b0, roi.max_turn_rate})
			                      : -$signed({1'b0, roi.max_turn_rate});
		end
		r.count = cnt[16:0];
		clear_frame_state();
		return r;
	endfunction

	// ---------------------------------------------------------------- transfers and checks

	task automatic report_field(string name, int exp_v, int act_v);
		if (exp_v != act_v) begin
			mismatches++;
			$error("%s: expected %0d, got %0d", name, exp_v, act_v);
		end
	endtask

	// Sample both channels before the edge updates anything
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("Mismatches found");
			$finish;
		end else begin
			in_taken = arst_n && in_valid && !in_stall;
			if (in_taken) begin
				accumulate_point(offer);
				points_sent++;
				if (offer.last)
					frame_q.insert(frame_q.size(), close_frame());
			end
			if (arst_n && out_valid && !out_stall) begin
				if (frame_q.size() == 0) begin
					mismatches++;
					$error("result transfer with no frame pending");
				end else begin
					want = frame_q.pop_front();
					report_field("obstacle_found", int'(want.found), int'(obstacle_found));
					report_field("closest_range", int'(want.near_mm), int'(closest_range));
					report_field("turn_command", int'(want.turn), int'(turn_command));
					report_field("box_point_count", int'(want.count), int'(box_point_count));
					frames_checked++;
				end
			end
		end
	end

	// Sender: hold a stalled point, otherwise offer the next one or idle
	always @(negedge clk) begin
		if (!in_valid || in_taken) begin
			if (arst_n && point_q.size() != 0 && (no_gaps || $urandom_range(99) >= 13)) begin
				offer       = point_q.pop_front();
				in_valid    <= 1'b1;
				point_x     <= offer.x;
				point_y     <= offer.y;
				point_z     <= offer.z;
				point_valid <= offer.pv;
				last_point  <= offer.last;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver: random stalls, plus one long hold-off on request
	always @(negedge clk) begin
		if (hold_cnt > 0) begin
			hold_cnt--;
			out_stall <= 1'b1;
		end else if (hold_req && !hold_done) begin
			hold_done = 1'b1;
			hold_cnt  = HOLD_CYCLES;
			out_stall <= 1'b1;
		end else begin
			out_stall <= !no_gaps && ($urandom_range(99) < 13);
		end
	end

	// ---------------------------------------------------------------- stimulus

	task automatic push_point(int x, int y, int z, bit pv, bit last);
		point_t p;
		p.x    = x[15:0];
		p.y    = y[15:0];
		p.z    = z[15:0];
		p.pv   = pv;
		p.last = last;
		point_q.insert(point_q.size(), p);
	endtask

	// Random point, inside the current box on the chosen side when the box is not empty
	function automatic point_t pick_point(bit in_box, bit left_side);
		point_t p;
		int     hw, lo_z, hi_z;
		hw   = int'(roi.roi_half_width);
		lo_z = int'(roi.roi_min_height);
		hi_z = int'(roi.roi_max_height);
		if (in_box && roi.roi_min_forward <= roi.roi_max_forward && lo_z <= hi_z) begin
			p.x = 16'($urandom_range(roi.roi_min_forward, roi.roi_max_forward));
			if (left_side || hw == 0)
				p.y = 16'($urandom_range(hw, 0));
			else
				p.y = 16'(-int'($urandom_range(hw, 1)));
			p.z = 16'(lo_z + int'($urandom_range(hi_z - lo_z, 0)));
		end else begin
			p.x = 16'($urandom);
			p.y = 16'($urandom);
			p.z = 16'($urandom);
		end
		p.pv   = ($urandom_range(99) < 92);
		p.last = 1'b0;
		return p;
	endfunction

	// Queue whole frames until about n points are pending
	task automatic queue_frames(int n, int max_len);
		point_t p;
		int     sent, len, in_pct, left_pct;
		sent = 0;
		while (sent < n) begin
			len      = int'($urandom_range(max_len, 1));
			in_pct   = int'($urandom_range(95, 40));
			left_pct = 10 + 40 * int'($urandom_range(2, 0));
			for (int i = 0; i < len; i++) begin
				p = pick_point(int'($urandom_range(99)) < in_pct,
					int'($urandom_range(99)) < left_pct);
				p.last = (i == len - 1);
				point_q.insert(point_q.size(), p);
			end
			sent += len;
		end
	endtask

	// Wait until every point is sent and every result checked, then let the block settle
	task automatic wait_idle();
		while (point_q.size() != 0 || in_valid || frame_q.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [pcod_pkg::CFG_INDEX_W-1:0] idx, int v);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= v[pcod_pkg::CFG_DATA_W-1:0];
		case (idx)
			pcod_pkg::REG_ROI_MIN_FORWARD: roi.roi_min_forward = v[14:0];
			pcod_pkg::REG_ROI_MAX_FORWARD: roi.roi_max_forward = v[14:0];
			pcod_pkg::REG_ROI_HALF_WIDTH:  roi.roi_half_width  = v[14:0];
			pcod_pkg::REG_ROI_MIN_HEIGHT:  roi.roi_min_height  = v[15:0];
			pcod_pkg::REG_ROI_MAX_HEIGHT:  roi.roi_max_height  = v[15:0];
			pcod_pkg::REG_MIN_POINTS:      roi.min_points      = v[16:0];
			pcod_pkg::REG_SIDE_DEADBAND:   roi.side_deadband   = v[16:0];
			pcod_pkg::REG_MAX_TURN_RATE:   roi.max_turn_rate   = v[15:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_config(int min_fwd, int max_fwd, int half_w, int min_h, int max_h,
			int min_pts, int deadband, int turn_rate);
		write_reg(pcod_pkg::REG_ROI_MIN_FORWARD, min_fwd);
		write_reg(pcod_pkg::REG_ROI_MAX_FORWARD, max_fwd);
		write_reg(pcod_pkg::REG_ROI_HALF_WIDTH, half_w);
		write_reg(pcod_pkg::REG_ROI_MIN_HEIGHT, min_h);
		write_reg(pcod_pkg::REG_ROI_MAX_HEIGHT, max_h);
		write_reg(pcod_pkg::REG_MIN_POINTS, min_pts);
		write_reg(pcod_pkg::REG_SIDE_DEADBAND, deadband);
		write_reg(pcod_pkg::REG_MAX_TURN_RATE, turn_rate);
		settings_run++;
	endtask

	initial begin
		roi.roi_min_forward = pcod_pkg::RST_ROI_MIN_FORWARD;
		roi.roi_max_forward = pcod_pkg::RST_ROI_MAX_FORWARD;
		roi.roi_half_width  = pcod_pkg::RST_ROI_HALF_WIDTH;
		roi.roi_min_height  = pcod_pkg::RST_ROI_MIN_HEIGHT;
		roi.roi_max_height  = pcod_pkg::RST_ROI_MAX_HEIGHT;
		roi.min_points      = pcod_pkg::RST_MIN_POINTS;
		roi.side_deadband   = pcod_pkg::RST_SIDE_DEADBAND;
		roi.max_turn_rate   = pcod_pkg::RST_MAX_TURN_RATE;
		clear_frame_state();
		turn_left    = 1'b1;
		settings_run = 1;

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed, reset settings: an invalid point that closes an empty frame
		push_point(0, 0, 0, 0, 1);
		// Box corners, one step outside each face, field extremes, a skipped point inside
		push_point(200, 0, 80, 1, 0);
		push_point(2000, 800, 1000, 1, 0);
		push_point(200, -800, 80, 1, 0);
		push_point(2000, -800, 1000, 1, 0);
		push_point(199, 0, 500, 1, 0);
		push_point(2001, 0, 500, 1, 0);
		push_point(1000, 801, 500, 1, 0);
		push_point(1000, -801, 500, 1, 0);
		push_point(1000, 0, 79, 1, 0);
		push_point(1000, 0, 1001, 1, 0);
		push_point(-32768, -32768, -32768, 1, 0);
		push_point(32767, 32767, 32767, 1, 0);
		push_point(500, -1, 500, 0, 0);
		push_point(500, 10, 300, 1, 0);
		push_point(600, -20, 300, 1, 0);
		push_point(700, 30, 300, 1, 0);
		push_point(800, -40, 300, 1, 0);
		push_point(250, 5, 300, 1, 1);
		// Too few box points: no obstacle, direction back to left
		push_point(300, -100, 200, 1, 0);
		push_point(400, -200, 200, 1, 0);
		push_point(500, -300, 200, 1, 1);
		wait_idle();

		queue_frames(400, 24);
		wait_idle();

		// Widest box, zero point threshold and deadband, full turn rate, no idling
		set_config(0, 32767, 32767, -32768, 32767, 0, 0, 65535);
		no_gaps = 1'b1;
		queue_frames(300, 24);
		wait_idle();
		no_gaps = 1'b0;

		// Forward bounds inverted: nothing is inside
		set_config(5000, 100, 800, 80, 1000, 1, 3, 800);
		queue_frames(150, 12);
		wait_idle();

		// Height bounds inverted
		set_config(200, 2000, 800, 32767, -32768, 1, 3, 800);
		queue_frames(150, 12);
		wait_idle();

		// Unreachable threshold, largest deadband, zero turn rate
		set_config(200, 2000, 800, 80, 1000, 131071, 131071, 0);
		queue_frames(100, 24);
		wait_idle();

		// Short frames while the receiver holds off for a long stretch
		set_config(100, 3000, 1500, -200, 1500, 1, 1, 1234);
		hold_req = 1'b1;
		queue_frames(400, 4);
		wait_idle();

		// Back to the reset values, written explicitly
		set_config(200, 2000, 800, 80, 1000, 8, 3, 800);
		queue_frames(400, 24);
		wait_idle();

		$display("Sent %0d points, checked %0d frame results over %0d register settings",
			points_sent, frames_checked, settings_run);
		$display("Field mismatches: %0d", mismatches);
		if (mismatches == 0 && frame_q.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
